/* src/ffa_pkg.sv */
// Shared widths, codes and defaults for the first-fit allocator.
package ffa_pkg;

   localparam int STORE_DEPTH_DEF = 1024;
   localparam int MAX_IDS_DEF     = 256;

   localparam int FUNC_W   = 2;
   localparam int SIZE_W   = 11;
   localparam int ID_W     = 9;
   localparam int STATUS_W = 2;
   localparam int UNITS_W  = 11;

   localparam logic [UNITS_W-1:0] UNITS_RESET = 11'd1024;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEFRAG = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BADID   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOIDS   = 2'd3;

endpackage

/* src/ffa_ifs.sv */
// Request, response and register-write channel interfaces.
interface ffa_req_if;
   logic                        valid;
   logic                        ready;
   logic [ffa_pkg::FUNC_W-1:0]  func;
   logic [ffa_pkg::SIZE_W-1:0]  alloc_size;
   logic [ffa_pkg::ID_W-1:0]    erase_id;
   modport source (output valid, func, alloc_size, erase_id, input ready);
   modport sink (input valid, func, alloc_size, erase_id, output ready);
endinterface

interface ffa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffa_pkg::STATUS_W-1:0]  status;
   logic [ffa_pkg::ID_W-1:0]      block_id;
   modport source (output valid, status, block_id, input ready);
   modport sink (input valid, status, block_id, output ready);
endinterface

interface ffa_csr_if;
   logic                         valid;
   logic                         ready;
   logic [ffa_pkg::UNITS_W-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* src/ffa_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* src/first_fit_allocator_with_compaction_top.sv */
// Top level: first-fit allocator with owner-map store and compaction.
//
//   channel  dir  payload                        handshake
//   req      in   func, alloc_size, erase_id     valid/ready
//   rsp      out  status, block_id               valid/ready
//   csr      in   data (store_units)             valid/ready
//
// Alloc scans up to min(store_units, STORE_DEPTH) owner map entries and then fills
// alloc_size of them, one entry a cycle, in the owner map RAM.
// Erase clears the block's entries; defragment compacts the whole map, then zeroes the rest.
// After reset a clearing pass zeroes all STORE_DEPTH entries of the owner map.
// A finished response waits in its output register while the next request is taken.
module first_fit_allocator_with_compaction_top #(
   parameter int STORE_DEPTH = ffa_pkg::STORE_DEPTH_DEF,
   parameter int MAX_IDS     = ffa_pkg::MAX_IDS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   ffa_req_if.sink   req_chan,
   ffa_rsp_if.source rsp_chan,
   ffa_csr_if.sink   csr_chan
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = (AW + 1 > ffa_pkg::SIZE_W) ? AW + 1 : ffa_pkg::SIZE_W;
   localparam int OW = $clog2(MAX_IDS + 1);
   localparam int FW = $clog2(MAX_IDS + 2);
   localparam int TW = $clog2(MAX_IDS);

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_ASCAN  = 9'b000000100,
      S_AFILL  = 9'b000001000,
      S_ELOOK  = 9'b000010000,
      S_ECLR   = 9'b000100000,
      S_DSCAN  = 9'b001000000,
      S_DZERO  = 9'b010000000,
      S_RESULT = 9'b100000000
   } state_type;

   state_type                         state_ff, state_in;
   logic [ffa_pkg::UNITS_W-1:0]       units_ff;
   logic [FW-1:0]                     fresh_ff, fresh_in;
   logic [MAX_IDS-1:0]                live_ff, live_in;
   logic [CW-1:0]                     iss_ff, iss_in;
   logic                              vld_ff, vld_in;
   logic [AW-1:0]                     pa_ff, pa_in;
   logic [CW-1:0]                     run_ff, run_in;
   logic [AW-1:0]                     base_ff, base_in;
   logic [ffa_pkg::SIZE_W-1:0]        size_ff, size_in;
   logic [CW-1:0]                     cnt_ff, cnt_in;
   logic [AW-1:0]                     s_ff, s_in;
   logic [ffa_pkg::SIZE_W-1:0]        len_ff, len_in;
   logic [TW-1:0]                     eidx_ff, eidx_in;
   logic [OW-1:0]                     prev_ff, prev_in;
   logic [ffa_pkg::STATUS_W-1:0]      res_st_ff, res_st_in;
   logic [ffa_pkg::ID_W-1:0]          res_id_ff, res_id_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ffa_pkg::STATUS_W-1:0]      rsp_st_ff, rsp_st_in;
   logic [ffa_pkg::ID_W-1:0]          rsp_id_ff, rsp_id_in;

   logic [CW-1:0]                     lim;
   logic                              own_we;
   logic [AW-1:0]                     own_waddr;
   logic [OW-1:0]                     own_wdata;
   logic [OW-1:0]                     own_rdata;
   logic                              st_we;
   logic [TW-1:0]                     st_waddr;
   logic [AW-1:0]                     st_wdata;
   logic [AW-1:0]                     st_rdata;
   logic                              len_we;
   logic [ffa_pkg::SIZE_W-1:0]        len_rdata;
   logic [TW-1:0]                     tbl_raddr;
   logic                              req_fire;
   logic                              erase_bad;
   logic [CW-1:0]                     run_next;

   ffa_ram #(.WIDTH(OW), .DEPTH(STORE_DEPTH)) u_owner (
      .clock (clock),
      .we    (own_we),
      .waddr (own_waddr),
      .wdata (own_wdata),
      .raddr (iss_ff[AW-1:0]),
      .rdata (own_rdata)
   );

   ffa_ram #(.WIDTH(AW), .DEPTH(MAX_IDS)) u_start (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (tbl_raddr),
      .rdata (st_rdata)
   );

   ffa_ram #(.WIDTH(ffa_pkg::SIZE_W), .DEPTH(MAX_IDS)) u_len (
      .clock (clock),
      .we    (len_we),
      .waddr (TW'(fresh_ff - FW'(1))),
      .wdata (size_ff),
      .raddr (tbl_raddr),
      .rdata (len_rdata)
   );

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = rsp_st_ff;
   assign rsp_chan.block_id = rsp_id_ff;

   assign lim = (CW'(units_ff) < CW'(STORE_DEPTH)) ? CW'(units_ff) : CW'(STORE_DEPTH);
   assign tbl_raddr = TW'(req_chan.erase_id - 9'd1);
   assign erase_bad = (req_chan.erase_id == '0) ||
                      (32'(req_chan.erase_id) > 32'(MAX_IDS)) ||
                      !live_ff[tbl_raddr];
   assign run_next = run_ff + CW'(1);

   always_comb begin
      state_in     = state_ff;
      fresh_in     = fresh_ff;
      live_in      = live_ff;
      iss_in       = iss_ff;
      vld_in       = 1'b0;
      pa_in        = pa_ff;
      run_in       = run_ff;
      base_in      = base_ff;
      size_in      = size_ff;
      cnt_in       = cnt_ff;
      s_in         = s_ff;
      len_in       = len_ff;
      eidx_in      = eidx_ff;
      prev_in      = prev_ff;
      res_st_in    = res_st_ff;
      res_id_in    = res_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_st_in    = rsp_st_ff;
      rsp_id_in    = rsp_id_ff;
      own_we       = 1'b0;
      own_waddr    = iss_ff[AW-1:0];
      own_wdata    = '0;
      st_we        = 1'b0;
      st_waddr     = TW'(fresh_ff - FW'(1));
      st_wdata     = base_ff;
      len_we       = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            own_we = 1'b1;
            iss_in = iss_ff + CW'(1);
            if (iss_ff == CW'(STORE_DEPTH - 1)) begin
               iss_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               iss_in  = '0;
               run_in  = '0;
               cnt_in  = '0;
               prev_in = '0;
               size_in = req_chan.alloc_size;
               eidx_in = tbl_raddr;
               res_id_in = '0;
               case (req_chan.func)
                  ffa_pkg::FUNC_ALLOC: begin
                     if (fresh_ff > FW'(MAX_IDS)) begin
                        res_st_in = ffa_pkg::STATUS_NOIDS;
                        state_in  = S_RESULT;
                     end else if (req_chan.alloc_size == '0 ||
                                  CW'(req_chan.alloc_size) > lim) begin
                        res_st_in = ffa_pkg::STATUS_NOSPACE;
                        state_in  = S_RESULT;
                     end else begin
                        state_in = S_ASCAN;
                     end
                  end
                  ffa_pkg::FUNC_ERASE: begin
                     if (erase_bad) begin
                        res_st_in = ffa_pkg::STATUS_BADID;
                        state_in  = S_RESULT;
                     end else begin
                        state_in = S_ELOOK;
                     end
                  end
                  ffa_pkg::FUNC_DEFRAG: begin
                     state_in = S_DSCAN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ASCAN: begin
            if (iss_ff < lim) begin
               iss_in = iss_ff + CW'(1);
               vld_in = 1'b1;
               pa_in  = iss_ff[AW-1:0];
            end
            if (vld_ff) begin
               if (own_rdata == '0) begin
                  run_in = run_next;
                  if (run_ff == '0) begin
                     base_in = pa_ff;
                  end
                  if (run_next >= CW'(size_ff)) begin
                     cnt_in   = '0;
                     state_in = S_AFILL;
                  end
               end else begin
                  run_in = '0;
               end
            end else if (iss_ff >= lim) begin
               res_st_in = ffa_pkg::STATUS_NOSPACE;
               state_in  = S_RESULT;
            end
         end
         S_AFILL: begin
            own_we    = 1'b1;
            own_waddr = AW'(CW'(base_ff) + cnt_ff);
            own_wdata = OW'(fresh_ff);
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff + CW'(1) == CW'(size_ff)) begin
               st_we     = 1'b1;
               len_we    = 1'b1;
               live_in[TW'(fresh_ff - FW'(1))] = 1'b1;
               res_st_in = ffa_pkg::STATUS_OK;
               res_id_in = ffa_pkg::ID_W'(fresh_ff);
               fresh_in  = fresh_ff + FW'(1);
               state_in  = S_RESULT;
            end
         end
         S_ELOOK: begin
            s_in     = st_rdata;
            len_in   = len_rdata;
            cnt_in   = '0;
            state_in = S_ECLR;
         end
         S_ECLR: begin
            if (cnt_ff < CW'(len_ff) &&
                (32'(s_ff) + 32'(cnt_ff)) < 32'(STORE_DEPTH)) begin
               own_we    = 1'b1;
               own_waddr = AW'(CW'(s_ff) + cnt_ff);
               cnt_in    = cnt_ff + CW'(1);
            end else begin
               live_in[eidx_ff] = 1'b0;
               state_in         = S_IDLE;
            end
         end
         S_DSCAN: begin
            if (iss_ff < CW'(STORE_DEPTH)) begin
               iss_in = iss_ff + CW'(1);
               vld_in = 1'b1;
            end
            if (vld_ff) begin
               prev_in = own_rdata;
               if (own_rdata != '0) begin
                  own_we    = 1'b1;
                  own_waddr = cnt_ff[AW-1:0];
                  own_wdata = own_rdata;
                  cnt_in    = cnt_ff + CW'(1);
                  if (own_rdata != prev_ff) begin
                     st_we    = 1'b1;
                     st_waddr = TW'(own_rdata - OW'(1));
                     st_wdata = cnt_ff[AW-1:0];
                  end
               end
            end else if (iss_ff >= CW'(STORE_DEPTH)) begin
               state_in = S_DZERO;
            end
         end
         S_DZERO: begin
            if (cnt_ff < CW'(STORE_DEPTH)) begin
               own_we    = 1'b1;
               own_waddr = cnt_ff[AW-1:0];
               cnt_in    = cnt_ff + CW'(1);
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_id_in    = res_id_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         units_ff     <= ffa_pkg::UNITS_RESET;
         fresh_ff     <= FW'(1);
         live_ff      <= '0;
         iss_ff       <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         live_ff      <= live_in;
         iss_ff       <= iss_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            units_ff <= csr_chan.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pa_ff     <= pa_in;
      run_ff    <= run_in;
      base_ff   <= base_in;
      size_ff   <= size_in;
      cnt_ff    <= cnt_in;
      s_ff      <= s_in;
      len_ff    <= len_in;
      eidx_ff   <= eidx_in;
      prev_ff   <= prev_in;
      res_st_ff <= res_st_in;
      res_id_ff <= res_id_in;
      rsp_st_ff <= rsp_st_in;
      rsp_id_ff <= rsp_id_in;
   end

endmodule

/* dv/tb_first_fit_allocator_with_compaction_top.sv */
// Testbench for the first-fit allocator: directed, random, response back-pressure and ID-exhaustion tests.
module tb_first_fit_allocator_with_compaction_top;

   localparam int DEPTH      = ffa_pkg::STORE_DEPTH_DEF;
   localparam int IDS        = ffa_pkg::MAX_IDS_DEF;
   localparam int QUIET_WAIT = 2 * DEPTH + 16;
   localparam int STALL_MAX  = 20000;
   localparam logic [ffa_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [ffa_pkg::STATUS_W-1:0] status;
      logic [ffa_pkg::ID_W-1:0]     block_id;
   } answer_type;

   logic clock;
   logic reset;

   ffa_req_if req_chan ();
   ffa_rsp_if rsp_chan ();
   ffa_csr_if csr_chan ();

   first_fit_allocator_with_compaction_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // allocator image
   logic [ffa_pkg::ID_W-1:0] owner [DEPTH];
   int                 blk_start [IDS];
   int                 blk_len [IDS];
   bit                 blk_live [IDS];
   int                 next_id;
   int                 units;

   answer_type         answers [$];
   int                 mismatches;
   int                 stall_cycles;
   int                 hold_cycles;
   int                 rsp_gap;
   bit                 no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void add_answer(answer_type ans);
      answers.insert(answers.size(), ans);
   endfunction

   function automatic int avail_units();
      return (units < DEPTH) ? units : DEPTH;
   endfunction

   function automatic void predict_alloc(int size);
      int lim, run, base;
      bit found;
      answer_type ans;
      lim = avail_units();
      run = 0;
      base = 0;
      found = 0;
      ans = '0;
      if (next_id > IDS) begin
         ans.status = ffa_pkg::STATUS_NOIDS;
      end else if (size == 0 || size > lim) begin
         ans.status = ffa_pkg::STATUS_NOSPACE;
      end else begin
         for (int a = 0; a < lim && !found; a++) begin
            if (owner[a] == '0) begin
               if (run == 0) base = a;
               run++;
               if (run >= size) found = 1;
            end else begin
               run = 0;
            end
         end
         if (!found) begin
            ans.status = ffa_pkg::STATUS_NOSPACE;
         end else begin
            for (int a = 0; a < size; a++) owner[base + a] = next_id[ffa_pkg::ID_W-1:0];
            blk_start[next_id - 1] = base;
            blk_len[next_id - 1] = size;
            blk_live[next_id - 1] = 1;
            ans.status = ffa_pkg::STATUS_OK;
            ans.block_id = next_id[ffa_pkg::ID_W-1:0];
            next_id++;
         end
      end
      add_answer(ans);
   endfunction

   function automatic void predict_erase(int id);
      answer_type ans;
      if (id == 0 || id > IDS || !blk_live[id - 1]) begin
         ans.status = ffa_pkg::STATUS_BADID;
         ans.block_id = '0;
         add_answer(ans);
      end else begin
         for (int a = 0; a < blk_len[id - 1] && blk_start[id - 1] + a < DEPTH; a++)
            owner[blk_start[id - 1] + a] = '0;
         blk_live[id - 1] = 0;
      end
   endfunction

   function automatic void predict_compact();
      int w, id;
      w = 0;
      for (int a = 0; a < DEPTH; a++) begin
         id = owner[a];
         if (id != 0 && id <= IDS) begin
            if (a == blk_start[id - 1]) blk_start[id - 1] = w;
            owner[w] = id[ffa_pkg::ID_W-1:0];
            w++;
         end
      end
      for (int a = w; a < DEPTH; a++) owner[a] = '0;
   endfunction

   function automatic int pick_live_id();
      int s;
      s = $urandom_range(0, IDS - 1);
      for (int k = 0; k < IDS; k++)
         if (blk_live[(s + k) % IDS]) return (s + k) % IDS + 1;
      return 0;
   endfunction

   function automatic int live_count();
      int n;
      n = 0;
      for (int k = 0; k < IDS; k++) n += blk_live[k];
      return n;
   endfunction

   // call right after a rising edge; returns right after the accepting edge
   task automatic send_request(logic [ffa_pkg::FUNC_W-1:0] func, int size, int id);
      int gap;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= func;
      req_chan.alloc_size <= size[ffa_pkg::SIZE_W-1:0];
      req_chan.erase_id   <= id[ffa_pkg::ID_W-1:0];
      case (func)
         ffa_pkg::FUNC_ALLOC: predict_alloc(size % (1 << ffa_pkg::SIZE_W));
         ffa_pkg::FUNC_ERASE: predict_erase(id % (1 << ffa_pkg::ID_W));
         ffa_pkg::FUNC_DEFRAG: predict_compact();
         default: ;
      endcase
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (answers.size() != 0) @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   task automatic write_units(int value);
      wait_idle();
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value[ffa_pkg::UNITS_W-1:0];
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      units = value % (1 << ffa_pkg::UNITS_W);
   endtask

   task automatic random_request();
      int r, id, size;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) size = $urandom_range(0, avail_units() + 2);
      else if ($urandom_range(0, 49) == 0) size = $urandom_range(1025, 2047);
      else size = $urandom_range(1, 24);
      if (r < 50) begin
         send_request(ffa_pkg::FUNC_ALLOC, size, $urandom_range(0, 511));
      end else if (r < 85) begin
         id = pick_live_id();
         if (id == 0 || $urandom_range(0, 7) == 0) id = $urandom_range(0, 511);
         send_request(ffa_pkg::FUNC_ERASE, $urandom_range(0, 2047), id);
      end else if (r < 94) begin
         send_request(ffa_pkg::FUNC_DEFRAG, $urandom_range(0, 2047), $urandom_range(0, 511));
      end else begin
         send_request(FUNC_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 511));
      end
   endtask

   task automatic test_directed();
      send_request(ffa_pkg::FUNC_ALLOC, 1, 0);
      send_request(ffa_pkg::FUNC_ALLOC, 1024, 0);
      send_request(ffa_pkg::FUNC_ALLOC, 0, 511);
      send_request(ffa_pkg::FUNC_ALLOC, 2047, 0);
      send_request(ffa_pkg::FUNC_ALLOC, 5, 0);
      send_request(ffa_pkg::FUNC_ALLOC, 3, 0);
      send_request(ffa_pkg::FUNC_ERASE, 0, 0);
      send_request(ffa_pkg::FUNC_ERASE, 2047, 511);
      send_request(ffa_pkg::FUNC_ERASE, 0, 257);
      send_request(ffa_pkg::FUNC_ERASE, 0, 200);
      send_request(ffa_pkg::FUNC_ERASE, 0, 2);
      send_request(ffa_pkg::FUNC_ERASE, 0, 2);
      send_request(ffa_pkg::FUNC_DEFRAG, 0, 0);
      send_request(ffa_pkg::FUNC_ALLOC, 4, 0);
      send_request(FUNC_UNUSED, 2047, 511);
      send_request(ffa_pkg::FUNC_ALLOC, 1017, 0);
      send_request(ffa_pkg::FUNC_ALLOC, 1, 0);
      write_units(0);
      send_request(ffa_pkg::FUNC_ALLOC, 1, 0);
      write_units(1);
      send_request(ffa_pkg::FUNC_ERASE, 0, 1);
      send_request(ffa_pkg::FUNC_ERASE, 0, 6);
      send_request(ffa_pkg::FUNC_ALLOC, 1, 0);
      send_request(ffa_pkg::FUNC_ALLOC, 1, 0);
   endtask

   task automatic test_random();
      int settings [6] = '{1024, 2047, 40, 1, 300, 1024};
      foreach (settings[p]) begin
         write_units(settings[p]);
         repeat (70) random_request();
      end
   endtask

   task automatic test_backpressure();
      write_units(1024);
      hold_cycles = 400;
      repeat (12) send_request(ffa_pkg::FUNC_ALLOC, $urandom_range(1, 8), 0);
      repeat (8) random_request();
   endtask

   task automatic test_ids_exhausted();
      int last_id;
      write_units(1024);
      no_idle = 1;
      while (next_id <= IDS) begin
         if (live_count() > 150) begin
            send_request(ffa_pkg::FUNC_ERASE, 0, pick_live_id());
         end else begin
            last_id = next_id;
            send_request(ffa_pkg::FUNC_ALLOC, $urandom_range(1, 3), 0);
            if (next_id == last_id) send_request(ffa_pkg::FUNC_ERASE, 0, pick_live_id());
         end
      end
      repeat (4) send_request(ffa_pkg::FUNC_ALLOC, 1, 0);
      send_request(ffa_pkg::FUNC_ERASE, 0, pick_live_id());
      send_request(ffa_pkg::FUNC_ALLOC, 1, 0);
   endtask

   // response sink
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
         rsp_gap <= $urandom_range(0, 10);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response status=%0d id=%0d",
                  rsp_chan.status, rsp_chan.block_id);
         end else begin
            want = answers.pop_front();
            if (rsp_chan.status !== want.status || rsp_chan.block_id !== want.block_id) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status=%0d id=%0d, got status=%0d id=%0d",
                     want.status, want.block_id, rsp_chan.status, rsp_chan.block_id);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
            || (csr_chan.valid && csr_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
         $display("FAIL first_fit_allocator_with_compaction_top");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = ffa_pkg::FUNC_ALLOC;
      req_chan.alloc_size = '0;
      req_chan.erase_id = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data = ffa_pkg::UNITS_RESET;
      rsp_chan.ready = 1'b0;
      mismatches = 0;
      stall_cycles = 0;
      hold_cycles = 0;
      rsp_gap = 0;
      no_idle = 0;
      for (int a = 0; a < DEPTH; a++) owner[a] = '0;
      for (int k = 0; k < IDS; k++) begin
         blk_start[k] = 0;
         blk_len[k] = 0;
         blk_live[k] = 0;
      end
      next_id = 1;
      units = ffa_pkg::UNITS_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      test_backpressure();
      test_ids_exhausted();
      wait_idle();
      if (mismatches == 0 && answers.size() == 0)
         $display("PASS first_fit_allocator_with_compaction_top");
      else
         $display("FAIL first_fit_allocator_with_compaction_top");
      $finish;
   end

endmodule
